>>> rtl/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the deque with remove-by-value block.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Field widths fixed by the item formats
   localparam int VAL_W       = 31;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int DQ_CAPACITY = 64;

   // Opcodes of an input item
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
   localparam logic [OP_W-1:0] OP_SIZE       = 3'd4;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ERR   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    value_res;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_type;

   // Classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_PUSH_BACK,
      CMD_PUSH_FRONT,
      CMD_POP,
      CMD_REMOVE,
      CMD_SIZE,
      CMD_DUMP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [VAL_W-1:0] value;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SCAN,
      S_SHIFT,
      S_DUMP,
      S_RESP
   } back_state_type;

endpackage
`default_nettype wire

>>> rtl/dq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front
// Accepts request items, decodes the opcode and holds the commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    dec_cmd;

   // Opcode decode; unused codes act as size
   always_comb begin
      dec_cmd.value = req_data.value;
      case (req_data.op)
         OP_PUSH_BACK:  dec_cmd.kind = CMD_PUSH_BACK;
         OP_PUSH_FRONT: dec_cmd.kind = CMD_PUSH_FRONT;
         OP_POP_FRONT:  dec_cmd.kind = CMD_POP;
         OP_REMOVE:     dec_cmd.kind = CMD_REMOVE;
         OP_SIZE:       dec_cmd.kind = CMD_SIZE;
         OP_DUMP:       dec_cmd.kind = CMD_DUMP;
         default:       dec_cmd.kind = CMD_SIZE;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue entries, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back
// Executes commands on the circular entry store: pushes, pops, key search
// with shift-up, size and list dump. Results leave through an output register.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; #(
   parameter int CAPACITY = DQ_CAPACITY
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [VAL_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    tag_ff, tag_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [VAL_W-1:0]    mem [CAPACITY];
   logic [VAL_W-1:0]    rdata_ff;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   logic [VAL_W-1:0]    mem_wdata;

   logic                out_free;
   logic                tag_last;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [VAL_W-1:0]    emit_value;
   logic                emit_last;
   logic                dump_issue;
   logic [IDX_W-1:0]    front_dec, front_inc;

   // Store slot of a list position
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [CNT_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = (IDX_W+1)'(front) + (IDX_W+1)'(pos);
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tag_last  = ((CNT_W+1)'(tag_ff) + (CNT_W+1)'(1)) == (CNT_W+1)'(count_ff);
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + IDX_W'(1);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      tag_in      = tag_ff;
      rd_vld_in   = rd_vld_ff;
      status_in   = status_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = slot_of(front_ff, CNT_W'(tag_ff - CNT_W'(1)));
      mem_wdata   = rdata_ff;
      mem_re      = 1'b0;
      mem_raddr   = slot_of(front_ff, pos_ff);
      emit        = 1'b0;
      emit_status = STAT_OK;
      emit_value  = '0;
      emit_last   = 1'b1;
      dump_issue  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_PUSH_BACK: begin
                     emit = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        emit_status = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(front_ff, count_ff);
                        mem_wdata = cmd.value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     emit = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        emit_status = STAT_FULL;
                     end else begin
                        front_in  = front_dec;
                        mem_we    = 1'b1;
                        mem_waddr = front_dec;
                        mem_wdata = cmd.value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = STAT_ERR;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = front_ff;
                        state_in  = S_POP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = STAT_ERR;
                     end else begin
                        key_in    = cmd.value;
                        pos_in    = '0;
                        rd_vld_in = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = STAT_EMPTY;
                     end else begin
                        pos_in    = '0;
                        rd_vld_in = 1'b0;
                        state_in  = S_DUMP;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         // Front value is in the read register
         S_POP: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_value = rdata_ff;
               front_in   = front_inc;
               count_in   = count_ff - CNT_W'(1);
               state_in   = S_IDLE;
            end
         end

         // Read one entry per cycle, compare the previous read with the key
         S_SCAN: begin
            if (rd_vld_ff && rdata_ff == key_ff) begin
               rd_vld_in = 1'b0;
               if (tag_last) begin
                  count_in  = count_ff - CNT_W'(1);
                  status_in = STAT_OK;
                  state_in  = S_RESP;
               end else begin
                  pos_in   = tag_ff + CNT_W'(1);
                  state_in = S_SHIFT;
               end
            end else if (rd_vld_ff && tag_last) begin
               rd_vld_in = 1'b0;
               status_in = STAT_ERR;
               state_in  = S_RESP;
            end else if (pos_ff < count_ff) begin
               mem_re    = 1'b1;
               tag_in    = pos_ff;
               rd_vld_in = 1'b1;
               pos_in    = pos_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
         end

         // Move each later entry up one place: read position p, write p-1
         S_SHIFT: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
            end
            if (rd_vld_ff && tag_last) begin
               rd_vld_in = 1'b0;
               count_in  = count_ff - CNT_W'(1);
               status_in = STAT_OK;
               state_in  = S_RESP;
            end else if (pos_ff < count_ff) begin
               mem_re    = 1'b1;
               tag_in    = pos_ff;
               rd_vld_in = 1'b1;
               pos_in    = pos_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
         end

         // Stream entries front to back, one read ahead of the output
         S_DUMP: begin
            if (rd_vld_ff && out_free) begin
               emit       = 1'b1;
               emit_value = rdata_ff;
               emit_last  = tag_last;
               rd_vld_in  = 1'b0;
               if (tag_last) begin
                  state_in = S_IDLE;
               end
            end
            dump_issue = (pos_ff < count_ff) && (!rd_vld_ff || out_free);
            if (dump_issue) begin
               mem_re    = 1'b1;
               tag_in    = pos_ff;
               rd_vld_in = 1'b1;
               pos_in    = pos_ff + CNT_W'(1);
            end
         end

         S_RESP: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = status_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = emit_status;
         rsp_data_in.value_res = emit_value;
         rsp_data_in.count     = COUNT_W'(count_in);
         rsp_data_in.last      = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      tag_ff      <= tag_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/deque_with_remove_by_value_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_core
// Bounded ordered list with push back/front, pop front, remove by key,
// size and dump.
// ----------------------------------------------------------------------------
// Request items (req_) carry an opcode and a value; result items (rsp_) carry
// status, value, entry count and a last mark. Both channels move an item on
// a clock edge with valid high and stall low.
// A front stage decodes requests into a two-entry command queue; the back
// stage owns the entry store (one write port, one registered read port).
// A push, size or error result passes through the command queue and the
// output register; a pop result also passes through the store read register.
// Push, size and error cases sustain one item per cycle unless rsp_ stalls.
// Remove by key reads entries from the front through the single store read
// port until the key matches, then moves each later entry up one place; a
// miss reads every entry.
// Dump streams count results, one per cycle unless rsp_ stalls.
// Reset empties the list at once; no clearing pass. A stall on rsp_
// holds the output register; the back stage then waits, and once the
// command queue fills, req_stall rises.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value_core import dq_pkg::*; #(
   parameter int CAPACITY = DQ_CAPACITY
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   dq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> verif/deque_with_remove_by_value_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_core_tb
// Self-checking bench for the bounded deque with remove-by-value.
// ----------------------------------------------------------------------------
// A queue of request items is built up front: a short directed list (empty
// list errors, both push ends, extreme values, duplicate keys, missing keys,
// reserved opcodes, dumps), then random phases that fill the list past full,
// churn it with removes and drain it to empty. A clocked driver sends the
// items with random gaps and updates a list model on every accepted item; a
// clocked monitor stalls at random and checks each result item field by
// field against the oldest predicted one.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value_core_tb;
   import dq_pkg::*;

   // Opcodes the block decodes as a size request
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   localparam int MAX_WAIT    = 17;
   localparam int TAIL_CYCLES = 80;
   localparam int LIMIT_TIME  = 4_000_000;

   typedef struct {
      req_type item;
      bit      drain_first;
   } stim_item_type;

   typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} op_mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   stim_item_type    stim_items[$];
   rsp_type          due_results[$];
   logic [VAL_W-1:0] model_entries[$];

   int  send_wait        = 0;
   bit  send_quiet       = 1'b0;
   int  hold_left        = 0;
   bit  recv_quiet       = 1'b0;
   bit  results_drained  = 1'b1;
   int  items_sent       = 0;
   int  results_checked  = 0;
   int  full_refusals    = 0;
   int  deepest          = 0;
   int  fail_count       = 0;

   deque_with_remove_by_value_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // List model: apply one accepted request, queue the results it causes
   function automatic void apply_deque_op(req_type it);
      rsp_type r;
      int      hit;
      r = '0;
      r.last = 1'b1;
      case (it.op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (model_entries.size() >= DQ_CAPACITY) begin
               r.status = STAT_FULL;
               full_refusals++;
            end else begin
               if (it.op == OP_PUSH_BACK) model_entries.push_back(it.value);
               else model_entries.push_front(it.value);
               r.status = STAT_OK;
            end
         end
         OP_POP_FRONT: begin
            if (model_entries.size() == 0) begin
               r.status = STAT_ERR;
            end else begin
               r.value_res = model_entries.pop_front();
               r.status = STAT_OK;
            end
         end
         OP_REMOVE: begin
            hit = -1;
            foreach (model_entries[i])
               if (hit < 0 && model_entries[i] == it.value) hit = i;
            if (hit >= 0) begin
               model_entries.delete(hit);
               r.status = STAT_OK;
            end else begin
               r.status = STAT_ERR;
            end
         end
         OP_DUMP: begin
            if (model_entries.size() == 0) r.status = STAT_EMPTY;
         end
         default: r.status = STAT_OK;
      endcase
      r.count = COUNT_W'(model_entries.size());
      if (model_entries.size() > deepest) deepest = model_entries.size();
      // A dump of a non-empty list streams every entry, front first
      if (it.op == OP_DUMP && model_entries.size() != 0) begin
         foreach (model_entries[i]) begin
            r.status    = STAT_OK;
            r.value_res = model_entries[i];
            r.last      = (i == model_entries.size() - 1);
            due_results.push_back(r);
         end
      end else begin
         due_results.push_back(r);
      end
   endfunction

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      logic [31:0] raw;
      raw = $urandom;
      // small pool so removes hit and duplicates show up
      if ($urandom_range(0, 99) < 60) raw = $urandom_range(0, 11);
      return raw[VAL_W-1:0];
   endfunction

   function automatic logic [OP_W-1:0] pick_op(op_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 50) return OP_PUSH_BACK;
            if (roll < 89) return OP_PUSH_FRONT;
            if (roll < 93) return OP_DUMP;
            if (roll < 96) return OP_REMOVE;
            if (roll < 97) return OP_POP_FRONT;
            if (roll < 98) return OP_SIZE;
            if (roll < 99) return OP_RSVD6;
            return OP_RSVD7;
         end
         MIX_CHURN: begin
            if (roll < 25) return OP_PUSH_BACK;
            if (roll < 40) return OP_PUSH_FRONT;
            if (roll < 55) return OP_POP_FRONT;
            if (roll < 80) return OP_REMOVE;
            if (roll < 85) return OP_SIZE;
            if (roll < 95) return OP_DUMP;
            if (roll < 98) return OP_RSVD6;
            return OP_RSVD7;
         end
         default: begin
            if (roll < 50) return OP_POP_FRONT;
            if (roll < 75) return OP_REMOVE;
            if (roll < 85) return OP_PUSH_BACK;
            if (roll < 93) return OP_DUMP;
            if (roll < 97) return OP_SIZE;
            if (roll < 99) return OP_RSVD6;
            return OP_RSVD7;
         end
      endcase
   endfunction

   task automatic add_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] value, bit drain);
      stim_item_type s;
      s.item.op    = op;
      s.item.value = value;
      s.drain_first = drain;
      stim_items.push_back(s);
   endtask

   task automatic add_phase(op_mix_type mix, int n);
      for (int k = 0; k < n; k++)
         add_item(pick_op(mix), pick_value(), k == 0);
   endtask

   // Sampled away from the active edge so the driver sees a settled value
   always @(negedge clock) results_drained = (due_results.size() == 0);

   // Driver: send queued items, model each accepted one
   always @(posedge clock) begin
      bit            took;
      stim_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            apply_deque_op(req_data);
            items_sent++;
         end
         if (!req_valid || took) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (stim_items.size() != 0 &&
                         (!stim_items[0].drain_first || (results_drained && !took))) begin
               nxt = stim_items.pop_front();
               req_data  <= nxt.item;
               req_valid <= 1'b1;
               send_wait <= draw_wait(send_quiet);
               if ($urandom_range(0, 19) == 0) send_quiet <= !send_quiet;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stall, compare each result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      int      gap;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result item with none expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.value_res !== want.value_res) begin
               $error("value_res: expected 0x%0h, got 0x%0h",
                      want.value_res, rsp_data.value_res);
               fail_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_data.count);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               fail_count++;
            end
         end
         results_checked++;
         gap = draw_wait(recv_quiet);
         if ($urandom_range(0, 19) == 0) recv_quiet <= !recv_quiet;
         hold_left <= gap;
         rsp_stall <= (gap != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end
   end

   // Stimulus and end of run
   initial begin
      // empty list corner cases
      add_item(OP_SIZE,       '0,           1'b0);
      add_item(OP_POP_FRONT,  '0,           1'b0);
      add_item(OP_DUMP,       '0,           1'b0);
      add_item(OP_REMOVE,     31'd5,        1'b0);
      // both ends, extreme and alternating values, a duplicate key
      add_item(OP_PUSH_BACK,  '0,           1'b0);
      add_item(OP_PUSH_BACK,  31'h7FFFFFFF, 1'b0);
      add_item(OP_PUSH_FRONT, 31'h2AAAAAAA, 1'b0);
      add_item(OP_PUSH_FRONT, 31'h55555555, 1'b0);
      add_item(OP_PUSH_BACK,  31'd7,        1'b0);
      add_item(OP_PUSH_BACK,  31'd7,        1'b0);
      add_item(OP_RSVD6,      31'h7FFFFFFF, 1'b0);
      add_item(OP_RSVD7,      31'h12345678, 1'b0);
      add_item(OP_DUMP,       '0,           1'b0);
      // first of two equal keys, missing key, front and middle entries
      add_item(OP_REMOVE,     31'd7,        1'b0);
      add_item(OP_REMOVE,     31'd12345,    1'b0);
      add_item(OP_REMOVE,     31'h55555555, 1'b0);
      add_item(OP_REMOVE,     31'h7FFFFFFF, 1'b0);
      add_item(OP_DUMP,       '0,           1'b0);
      add_item(OP_POP_FRONT,  '0,           1'b0);
      add_item(OP_SIZE,       31'h7FFFFFFF, 1'b0);
      add_item(OP_POP_FRONT,  '0,           1'b1);
      add_item(OP_POP_FRONT,  '0,           1'b0);
      add_item(OP_POP_FRONT,  '0,           1'b0);
      // random phases: past full, churn, back to empty, churn again
      add_phase(MIX_FILL,  100);
      add_phase(MIX_CHURN, 80);
      add_phase(MIX_DRAIN, 80);
      add_phase(MIX_CHURN, 70);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (stim_items.size() != 0 || req_valid) @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d request items, checked %0d result items.",
               items_sent, results_checked);
      $display("Deepest list %0d entries, %0d pushes refused on a full list.",
               deepest, full_refusals);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_TIME);
      $display("Timed out with %0d result items still expected", due_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
rtl/dq_pkg.sv
rtl/dq_front.sv
rtl/dq_back.sv
rtl/deque_with_remove_by_value_core.sv
verif/deque_with_remove_by_value_core_tb.sv
